### sv/radiative_boundary_rhs_assert.svh
// Assertion macros for the radiative boundary right-hand side block
`ifndef RADIATIVE_BOUNDARY_RHS_ASSERT_SVH
`define RADIATIVE_BOUNDARY_RHS_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define RBR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define RBR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rbr_pkg.sv
// Shared widths, codes and reset values of the radiative boundary block
`timescale 1ns / 1ps
package rbr_pkg;

    localparam int DATA_W        = 32;
    localparam int REG_W         = 31;
    localparam int KIND_W        = 6;
    localparam int ERR_W         = 2;
    localparam int AXES          = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ROOT_W        = 32;
    localparam int DIV_NUM_W     = 63;
    localparam int DIV_LANES     = 4;

    localparam logic [DATA_W-1:0] VAR0_RST  = '0;
    localparam logic [REG_W-1:0]  SPEED_RST = 31'd65536;
    localparam logic [REG_W-1:0]  INV_RST   = 31'd32768;
    localparam logic [DATA_W-1:0] RATE_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] RATE_MIN  = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VAR0,
        CFG_SPEED,
        CFG_INV_X,
        CFG_INV_Y,
        CFG_INV_Z
    } cfg_idx_t;

    typedef enum logic [1:0] {
        AXIS_INTERIOR,
        AXIS_UPPER,
        AXIS_LOWER,
        AXIS_INVALID
    } axis_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK,
        ERR_KIND,
        ERR_RADIUS,
        ERR_SAT
    } err_t;

endpackage

### sv/rbr_cfg_if.sv
// Register write channel of the radiative boundary block
`timescale 1ns / 1ps
interface rbr_cfg_if
    import rbr_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/rbr_in_if.sv
// Input item channel of the radiative boundary block
`timescale 1ns / 1ps
interface rbr_in_if
    import rbr_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] center_value;
    logic signed [DATA_W-1:0] x_first;
    logic signed [DATA_W-1:0] x_second;
    logic signed [DATA_W-1:0] y_first;
    logic signed [DATA_W-1:0] y_second;
    logic signed [DATA_W-1:0] z_first;
    logic signed [DATA_W-1:0] z_second;
    logic [KIND_W-1:0]        boundary_kind;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output center_value, output x_first, output x_second,
                    output y_first, output y_second, output z_first,
                    output z_second, output boundary_kind, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input center_value, input x_first, input x_second,
                    input y_first, input y_second, input z_first,
                    input z_second, input boundary_kind, output ready);
endinterface

### sv/rbr_out_if.sv
// Result item channel of the radiative boundary block
`timescale 1ns / 1ps
interface rbr_out_if
    import rbr_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] rate_of_change;
    logic [ERR_W-1:0]         error_code;

    modport source (output valid, output rate_of_change, output error_code, input ready);
    modport sink   (input valid, input rate_of_change, input error_code, output ready);
endinterface

### sv/rbr_divider.sv
// Pipelined restoring divider, one quotient bit per stage, lanes share the divisor
`timescale 1ns / 1ps
module rbr_divider
    import rbr_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = ROOT_W,
    parameter int LANES = DIV_LANES
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num [LANES],
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo [LANES]
);

    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W][LANES];
    logic [NUM_W-1:0] num_reg [NUM_W][LANES];
    logic [NUM_W-1:0] quo_reg [NUM_W][LANES];
    logic [DEN_W-1:0] rem_next [NUM_W][LANES];
    logic [NUM_W-1:0] num_next [NUM_W][LANES];
    logic [NUM_W-1:0] quo_next [NUM_W][LANES];
    logic [DEN_W-1:0] den_in [NUM_W];

    for (genvar j = 0; j < NUM_W; j++) begin : g_stage
        if (j == 0) begin : g_first
            assign den_in[j] = den;
        end else begin : g_rest
            assign den_in[j] = den_reg[j-1];
        end
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DEN_W-1:0] rem_in;
            logic [NUM_W-1:0] num_in;
            logic [NUM_W-1:0] quo_in;
            logic [DEN_W:0]   trial;
            logic             ge;
            if (j == 0) begin : g_first
                assign rem_in = '0;
                assign num_in = num[l];
                assign quo_in = '0;
            end else begin : g_rest
                assign rem_in = rem_reg[j-1][l];
                assign num_in = num_reg[j-1][l];
                assign quo_in = quo_reg[j-1][l];
            end
            assign trial          = {rem_in, num_in[NUM_W-1]};
            assign ge             = trial >= {1'b0, den_in[j]};
            assign rem_next[j][l] = ge ? DEN_W'(trial - {1'b0, den_in[j]})
                                       : trial[DEN_W-1:0];
            assign num_next[j][l] = num_in << 1;
            assign quo_next[j][l] = {quo_in[NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NUM_W; j++)
            begin
                den_reg[j] <= den_in[j];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[j][l] <= rem_next[j][l];
                    num_reg[j][l] <= num_next[j][l];
                    quo_reg[j][l] <= quo_next[j][l];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quo[l] = quo_reg[NUM_W-1][l];
        end
    end

endmodule

### sv/radiative_boundary_rhs.sv
// Pipeline: 103 register stages between an accepted item and its result.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// Depth is set by the 32-stage square root and the 63-stage divider for v0*|x_i|/r and v0*|u-var0|/r.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
`timescale 1ns / 1ps
`include "radiative_boundary_rhs_assert.svh"
module radiative_boundary_rhs
    import rbr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rbr_cfg_if.sink   cfg,
    rbr_in_if.sink    point,
    rbr_out_if.source result
);

    localparam int R2_W      = 64;
    localparam int SQ_STAGES = 32;
    localparam int VNUM_W    = 62;
    localparam int DIFF_W    = 36;
    localparam int DMAG_W    = 35;
    localparam int UDIFF_W   = 33;
    localparam int DLO_W     = 63;
    localparam int DHI_W     = 34;
    localparam int DPROD_W   = 66;
    localparam int MAG_W     = 61;
    localparam int PA_W      = 63;
    localparam int PB_W      = 60;
    localparam int TPROD_W   = 92;
    localparam int SUM_W     = 64;
    localparam logic [MAG_W-1:0] CLAMP_LIMIT = {1'b1, {(MAG_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = 64'sd2147483647;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [AXES-1:0][DATA_W-1:0] pos;
        logic [DATA_W-1:0]           u;
        logic [AXES-1:0][DATA_W-1:0] first;
        logic [AXES-1:0][DATA_W-1:0] second;
        logic [KIND_W-1:0]           kind;
    } s1_t;

    typedef struct packed {
        logic [AXES-1:0]             pneg;
        logic [AXES-1:0][R2_W-1:0]   sq;
        logic [AXES-1:0][VNUM_W-1:0] vnum;
        logic [AXES-1:0][DIFF_W-1:0] dval;
        logic [UDIFF_W-1:0]          diff;
        logic                        kind_err;
        logic                        zero_r;
    } s2_t;

    typedef struct packed {
        logic [R2_W-1:0]             r2;
        logic [AXES-1:0][DLO_W-1:0]  dlo;
        logic [AXES-1:0][DHI_W-1:0]  dhi;
        logic [AXES-1:0]             dneg;
        logic [AXES-1:0]             pneg;
        logic [AXES-1:0][VNUM_W-1:0] vnum;
        logic [DIV_NUM_W-1:0]        dnum;
        logic                        diffneg;
        logic                        kind_err;
        logic                        zero_r;
    } s3_t;

    typedef struct packed {
        logic [AXES-1:0][MAG_W-1:0]  dmag;
        logic                        dsat;
        logic [AXES-1:0]             tneg;
        logic [AXES-1:0][VNUM_W-1:0] vnum;
        logic [DIV_NUM_W-1:0]        dnum;
        logic                        diffneg;
        logic                        kind_err;
        logic                        zero_r;
    } sq_carry_t;

    typedef struct packed {
        logic [AXES-1:0][MAG_W-1:0] dmag;
        logic                       dsat;
        logic [AXES-1:0]            tneg;
        logic                       diffneg;
        logic                       kind_err;
        logic                       zero_r;
    } dv_carry_t;

    typedef struct packed {
        logic [AXES-1:0][PA_W-1:0] pa;
        logic [AXES-1:0][PB_W-1:0] pb;
        logic [AXES-1:0]           tneg;
        logic [MAG_W-1:0]          dmc;
        logic                      sat;
        logic                      diffneg;
        logic                      kind_err;
        logic                      zero_r;
    } s5_t;

    typedef struct packed {
        logic [AXES-1:0][MAG_W-1:0] tmag;
        logic [AXES-1:0]            tneg;
        logic [MAG_W-1:0]           dmc;
        logic                       sat;
        logic                       diffneg;
        logic                       kind_err;
        logic                       zero_r;
    } s6_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    sat;
        logic                    kind_err;
        logic                    zero_r;
    } s7_t;

    logic signed [DATA_W-1:0] var0_reg;
    logic [REG_W-1:0]         speed_reg;
    logic [REG_W-1:0]         inv_reg [AXES];

    logic en;

    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg, vld6_reg, vld7_reg;
    logic out_vld_reg;
    logic sq_vld_reg [SQ_STAGES];
    logic dv_vld_reg [DIV_NUM_W];

    s1_t       s1_reg, s1_next;
    s2_t       s2_reg, s2_next;
    s3_t       s3_reg, s3_next;
    sq_carry_t s4_reg, s4_next;
    logic [R2_W-1:0] r2_reg;
    sq_carry_t sq_carry_reg [SQ_STAGES];
    logic [R2_W-1:0] sqn_reg [SQ_STAGES];
    logic [R2_W-1:0] sqr_reg [SQ_STAGES];
    logic [R2_W-1:0] sqn_next [SQ_STAGES];
    logic [R2_W-1:0] sqr_next [SQ_STAGES];
    dv_carry_t dv_carry_next;
    dv_carry_t dv_carry_reg [DIV_NUM_W];
    s5_t       s5_reg, s5_next;
    s6_t       s6_reg, s6_next;
    s7_t       s7_reg, s7_next;
    logic [DATA_W-1:0] out_rate_reg, out_rate_next;
    err_t              out_err_reg, out_err_next;

    logic [DATA_W-1:0]        pmag_s2 [AXES];
    logic signed [DIFF_W-1:0] u36;
    logic signed [DIFF_W-1:0] f36 [AXES];
    logic signed [DIFF_W-1:0] s36 [AXES];
    logic signed [DIFF_W-1:0] os36 [AXES];
    logic [DMAG_W-1:0]        dmag_s3 [AXES];
    logic [UDIFF_W-1:0]       diffmag_s3;
    logic [DPROD_W-1:0]       dprod_s4 [AXES];
    logic [DPROD_W-1:0]       dsh_s4 [AXES];
    logic [DIV_NUM_W-1:0]     div_num [DIV_LANES];
    logic [DIV_NUM_W-1:0]     div_quo [DIV_LANES];
    logic [REG_W-1:0]         vm_s5 [AXES];
    logic [TPROD_W-1:0]       tprod_s6 [AXES];
    logic [TPROD_W-1:0]       tsh_s6 [AXES];
    logic signed [SUM_W-1:0]  tsgn_s7 [AXES];
    logic signed [SUM_W-1:0]  dsgn_s7;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var0_reg  <= VAR0_RST;
            speed_reg <= SPEED_RST;
            for (int i = 0; i < AXES; i++)
            begin
                inv_reg[i] <= INV_RST;
            end
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_VAR0:  var0_reg   <= cfg.data;
                CFG_SPEED: speed_reg  <= cfg.data[REG_W-1:0];
                CFG_INV_X: inv_reg[0] <= cfg.data[REG_W-1:0];
                CFG_INV_Y: inv_reg[1] <= cfg.data[REG_W-1:0];
                CFG_INV_Z: inv_reg[2] <= cfg.data[REG_W-1:0];
                default: ;
            endcase
        end
    end

    // advance everything unless the output item is held
    assign en          = !out_vld_reg || result.ready;
    assign point.ready = en;

    always_comb
    begin
        s1_next.pos[0]    = point.pos_x;
        s1_next.pos[1]    = point.pos_y;
        s1_next.pos[2]    = point.pos_z;
        s1_next.u         = point.center_value;
        s1_next.first[0]  = point.x_first;
        s1_next.second[0] = point.x_second;
        s1_next.first[1]  = point.y_first;
        s1_next.second[1] = point.y_second;
        s1_next.first[2]  = point.z_first;
        s1_next.second[2] = point.z_second;
        s1_next.kind      = point.boundary_kind;
    end

    // squares, velocity numerators, raw differences
    assign u36 = DIFF_W'($signed(s1_reg.u));

    always_comb
    begin
        s2_next.kind_err = 1'b0;
        s2_next.zero_r   = 1'b1;
        s2_next.diff     = UDIFF_W'($signed(s1_reg.u)) - UDIFF_W'(var0_reg);
        for (int i = 0; i < AXES; i++)
        begin
            s2_next.pneg[i] = s1_reg.pos[i][DATA_W-1];
            pmag_s2[i]      = s2_next.pneg[i] ? (~s1_reg.pos[i] + 1'b1) : s1_reg.pos[i];
            s2_next.sq[i]   = R2_W'(pmag_s2[i]) * R2_W'(pmag_s2[i]);
            s2_next.vnum[i] = VNUM_W'(speed_reg) * VNUM_W'(pmag_s2[i]);
            f36[i]  = DIFF_W'($signed(s1_reg.first[i]));
            s36[i]  = DIFF_W'($signed(s1_reg.second[i]));
            os36[i] = (u36 <<< 1) + u36 - (f36[i] <<< 2) + s36[i];
            case (axis_t'(s1_reg.kind[2*i +: 2]))
                AXIS_INTERIOR: s2_next.dval[i] = f36[i] - s36[i];
                AXIS_UPPER:    s2_next.dval[i] = os36[i];
                default:       s2_next.dval[i] = -os36[i];
            endcase
            if (s1_reg.kind[2*i +: 2] == AXIS_INVALID)
            begin
                s2_next.kind_err = 1'b1;
            end
            if (s1_reg.pos[i] != '0)
            begin
                s2_next.zero_r = 1'b0;
            end
        end
    end

    // radius squared, partial products of the derivative, damping numerator
    always_comb
    begin
        s3_next.r2       = s2_reg.sq[0] + s2_reg.sq[1] + s2_reg.sq[2];
        s3_next.pneg     = s2_reg.pneg;
        s3_next.vnum     = s2_reg.vnum;
        s3_next.kind_err = s2_reg.kind_err;
        s3_next.zero_r   = s2_reg.zero_r;
        s3_next.diffneg  = s2_reg.diff[UDIFF_W-1];
        diffmag_s3       = s3_next.diffneg ? (~s2_reg.diff + 1'b1) : s2_reg.diff;
        s3_next.dnum     = DIV_NUM_W'(speed_reg) * DIV_NUM_W'(diffmag_s3);
        for (int i = 0; i < AXES; i++)
        begin
            s3_next.dneg[i] = s2_reg.dval[i][DIFF_W-1];
            dmag_s3[i] = DMAG_W'(s3_next.dneg[i] ? (~s2_reg.dval[i] + 1'b1)
                                                  : s2_reg.dval[i]);
            s3_next.dlo[i] = DLO_W'(dmag_s3[i][31:0]) * DLO_W'(inv_reg[i]);
            s3_next.dhi[i] = DHI_W'(dmag_s3[i][DMAG_W-1:32]) * DHI_W'(inv_reg[i]);
        end
    end

    // derivative magnitude, rescaled and clamped
    always_comb
    begin
        s4_next.dsat     = 1'b0;
        s4_next.vnum     = s3_reg.vnum;
        s4_next.dnum     = s3_reg.dnum;
        s4_next.diffneg  = s3_reg.diffneg;
        s4_next.kind_err = s3_reg.kind_err;
        s4_next.zero_r   = s3_reg.zero_r;
        s4_next.tneg     = s3_reg.pneg ^ s3_reg.dneg;
        for (int i = 0; i < AXES; i++)
        begin
            dprod_s4[i] = DPROD_W'(s3_reg.dlo[i]) + (DPROD_W'(s3_reg.dhi[i]) << 32);
            dsh_s4[i]   = dprod_s4[i] >> FRAC_BITS;
            if (dsh_s4[i] > DPROD_W'(CLAMP_LIMIT))
            begin
                s4_next.dmag[i] = CLAMP_LIMIT;
                s4_next.dsat    = 1'b1;
            end
            else
            begin
                s4_next.dmag[i] = MAG_W'(dsh_s4[i]);
            end
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
        localparam logic [R2_W-1:0] STEP_BIT = R2_W'(1) << (R2_W - 2 - 2 * k);
        logic [R2_W-1:0] n_in;
        logic [R2_W-1:0] r_in;
        logic [R2_W-1:0] trial;
        if (k == 0) begin : g_first
            assign n_in = r2_reg;
            assign r_in = '0;
        end else begin : g_rest
            assign n_in = sqn_reg[k-1];
            assign r_in = sqr_reg[k-1];
        end
        assign trial       = r_in + STEP_BIT;
        assign sqn_next[k] = (n_in >= trial) ? n_in - trial : n_in;
        assign sqr_next[k] = (n_in >= trial) ? (r_in >> 1) + STEP_BIT : r_in >> 1;
    end

    // v0*|x_i| / r and v0*|u-var0| / r
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            div_num[i] = DIV_NUM_W'(sq_carry_reg[SQ_STAGES-1].vnum[i]);
        end
        div_num[AXES] = sq_carry_reg[SQ_STAGES-1].dnum;
    end

    rbr_divider #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (ROOT_W),
        .LANES (DIV_LANES)
    ) u_divider (
        .clk (clk),
        .en  (en),
        .num (div_num),
        .den (sqr_reg[SQ_STAGES-1][ROOT_W-1:0]),
        .quo (div_quo)
    );

    always_comb
    begin
        dv_carry_next.dmag     = sq_carry_reg[SQ_STAGES-1].dmag;
        dv_carry_next.dsat     = sq_carry_reg[SQ_STAGES-1].dsat;
        dv_carry_next.tneg     = sq_carry_reg[SQ_STAGES-1].tneg;
        dv_carry_next.diffneg  = sq_carry_reg[SQ_STAGES-1].diffneg;
        dv_carry_next.kind_err = sq_carry_reg[SQ_STAGES-1].kind_err;
        dv_carry_next.zero_r   = sq_carry_reg[SQ_STAGES-1].zero_r;
    end

    // term partial products, damping clamp
    always_comb
    begin
        s5_next.tneg     = dv_carry_reg[DIV_NUM_W-1].tneg;
        s5_next.diffneg  = dv_carry_reg[DIV_NUM_W-1].diffneg;
        s5_next.kind_err = dv_carry_reg[DIV_NUM_W-1].kind_err;
        s5_next.zero_r   = dv_carry_reg[DIV_NUM_W-1].zero_r;
        s5_next.sat      = dv_carry_reg[DIV_NUM_W-1].dsat;
        for (int i = 0; i < AXES; i++)
        begin
            vm_s5[i]      = div_quo[i][REG_W-1:0];
            s5_next.pa[i] = PA_W'(vm_s5[i]) * PA_W'(dv_carry_reg[DIV_NUM_W-1].dmag[i][31:0]);
            s5_next.pb[i] = PB_W'(vm_s5[i])
                          * PB_W'(dv_carry_reg[DIV_NUM_W-1].dmag[i][MAG_W-1:32]);
        end
        if (div_quo[AXES] > DIV_NUM_W'(CLAMP_LIMIT))
        begin
            s5_next.dmc = CLAMP_LIMIT;
            s5_next.sat = 1'b1;
        end
        else
        begin
            s5_next.dmc = MAG_W'(div_quo[AXES]);
        end
    end

    // term magnitudes, rescaled and clamped
    always_comb
    begin
        s6_next.tneg     = s5_reg.tneg;
        s6_next.dmc      = s5_reg.dmc;
        s6_next.sat      = s5_reg.sat;
        s6_next.diffneg  = s5_reg.diffneg;
        s6_next.kind_err = s5_reg.kind_err;
        s6_next.zero_r   = s5_reg.zero_r;
        for (int i = 0; i < AXES; i++)
        begin
            tprod_s6[i] = TPROD_W'(s5_reg.pa[i]) + (TPROD_W'(s5_reg.pb[i]) << 32);
            tsh_s6[i]   = tprod_s6[i] >> FRAC_BITS;
            if (tsh_s6[i] > TPROD_W'(CLAMP_LIMIT))
            begin
                s6_next.tmag[i] = CLAMP_LIMIT;
                s6_next.sat     = 1'b1;
            end
            else
            begin
                s6_next.tmag[i] = MAG_W'(tsh_s6[i]);
            end
        end
    end

    // signed sum
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            tsgn_s7[i] = s6_reg.tneg[i] ? -SUM_W'(s6_reg.tmag[i]) : SUM_W'(s6_reg.tmag[i]);
        end
        dsgn_s7          = s6_reg.diffneg ? -SUM_W'(s6_reg.dmc) : SUM_W'(s6_reg.dmc);
        s7_next.sum      = -tsgn_s7[0] - tsgn_s7[1] - tsgn_s7[2] - dsgn_s7;
        s7_next.sat      = s6_reg.sat;
        s7_next.kind_err = s6_reg.kind_err;
        s7_next.zero_r   = s6_reg.zero_r;
    end

    // saturate and pick the error code
    always_comb
    begin
        out_rate_next = s7_reg.sum[DATA_W-1:0];
        out_err_next  = ERR_OK;
        if (s7_reg.kind_err)
        begin
            out_rate_next = '0;
            out_err_next  = ERR_KIND;
        end
        else if (s7_reg.zero_r)
        begin
            out_rate_next = '0;
            out_err_next  = ERR_RADIUS;
        end
        else if (s7_reg.sat)
        begin
            out_rate_next = (s7_reg.sum < 0) ? RATE_MIN : RATE_MAX;
            out_err_next  = ERR_SAT;
        end
        else if (s7_reg.sum > SUM_MAX)
        begin
            out_rate_next = RATE_MAX;
            out_err_next  = ERR_SAT;
        end
        else if (s7_reg.sum < SUM_MIN)
        begin
            out_rate_next = RATE_MIN;
            out_err_next  = ERR_SAT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            vld3_reg    <= 1'b0;
            vld4_reg    <= 1'b0;
            vld5_reg    <= 1'b0;
            vld6_reg    <= 1'b0;
            vld7_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                sq_vld_reg[k] <= 1'b0;
            end
            for (int k = 0; k < DIV_NUM_W; k++)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld1_reg      <= point.valid;
            vld2_reg      <= vld1_reg;
            vld3_reg      <= vld2_reg;
            vld4_reg      <= vld3_reg;
            sq_vld_reg[0] <= vld4_reg;
            for (int k = 1; k < SQ_STAGES; k++)
            begin
                sq_vld_reg[k] <= sq_vld_reg[k-1];
            end
            dv_vld_reg[0] <= sq_vld_reg[SQ_STAGES-1];
            for (int k = 1; k < DIV_NUM_W; k++)
            begin
                dv_vld_reg[k] <= dv_vld_reg[k-1];
            end
            vld5_reg    <= dv_vld_reg[DIV_NUM_W-1];
            vld6_reg    <= vld5_reg;
            vld7_reg    <= vld6_reg;
            out_vld_reg <= vld7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            r2_reg <= s3_reg.r2;
            sq_carry_reg[0] <= s4_reg;
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                sqn_reg[k] <= sqn_next[k];
                sqr_reg[k] <= sqr_next[k];
            end
            for (int k = 1; k < SQ_STAGES; k++)
            begin
                sq_carry_reg[k] <= sq_carry_reg[k-1];
            end
            dv_carry_reg[0] <= dv_carry_next;
            for (int k = 1; k < DIV_NUM_W; k++)
            begin
                dv_carry_reg[k] <= dv_carry_reg[k-1];
            end
            s5_reg       <= s5_next;
            s6_reg       <= s6_next;
            s7_reg       <= s7_next;
            out_rate_reg <= out_rate_next;
            out_err_reg  <= out_err_next;
        end
    end

    assign result.valid          = out_vld_reg;
    assign result.rate_of_change = out_rate_reg;
    assign result.error_code     = out_err_reg;

    `RBR_ASSERT_NOW(a_root_zero, sq_vld_reg[SQ_STAGES-1], (sqr_reg[SQ_STAGES-1] == '0) == sq_carry_reg[SQ_STAGES-1].zero_r, "root and zero-radius flag disagree")
    `RBR_ASSERT_NOW(a_term_clamped, vld6_reg, s6_reg.tmag[0] <= CLAMP_LIMIT && s6_reg.tmag[1] <= CLAMP_LIMIT && s6_reg.tmag[2] <= CLAMP_LIMIT, "term magnitude above clamp")
    `RBR_ASSERT_NOW(a_err_zero_rate, out_vld_reg && (out_err_reg == ERR_KIND || out_err_reg == ERR_RADIUS), out_rate_reg == '0, "error item carries nonzero rate")
    `RBR_ASSERT_NEXT(a_stall_keeps_out, !en, out_vld_reg, "held output item dropped")

endmodule
